// ===== rtl/drf_pkg.sv =====
`timescale 1ns / 1ps

package drf_pkg;

  // Row layout
  localparam int NUM_CLASSES = 16;
  localparam int FIELD_CNT   = 5;
  localparam int ROW_LEN     = FIELD_CNT + NUM_CLASSES;
  localparam int POS_W       = $clog2(ROW_LEN);
  localparam int FLD_IDX_W   = $clog2(FIELD_CNT);

  // Field widths
  localparam int VAL_W      = 16;
  localparam int FRAC_W     = VAL_W - 1;
  localparam int ROW_W      = 15;
  localparam int CLS_W      = 4;
  localparam int IMG_W      = 13;
  localparam int EDGE_W     = 14;
  localparam int SIZE_W     = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BOX_LIMIT  = 4096;

  // Products: (2c - s) * size and s * size
  localparam int DIFF_W      = VAL_W + 2;
  localparam int EDGE_PROD_W = DIFF_W + IMG_W + 1;
  localparam int SIZE_PROD_W = VAL_W + IMG_W;

  // Result packing, lowest field first
  localparam int OFS_ROW   = 0;
  localparam int OFS_CLS   = OFS_ROW + ROW_W;
  localparam int OFS_CONF  = OFS_CLS + CLS_W;
  localparam int OFS_LEFT  = OFS_CONF + VAL_W;
  localparam int OFS_TOP   = OFS_LEFT + EDGE_W;
  localparam int OFS_WIDTH = OFS_TOP + EDGE_W;
  localparam int OFS_HEIGHT = OFS_WIDTH + SIZE_W;
  localparam int OUT_BITS  = OFS_HEIGHT + SIZE_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONF_TH    = 3'd0,
    CFG_SCORE_TH   = 3'd1,
    CFG_SPECIAL    = 3'd2,
    CFG_SPECIAL_TH = 3'd3,
    CFG_IMG_W      = 3'd4,
    CFG_IMG_H      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [VAL_W-1:0] conf_th;
    logic [VAL_W-1:0] score_th;
    logic [CLS_W-1:0] special;
    logic [VAL_W-1:0] special_th;
    logic [IMG_W-1:0] img_w;
    logic [IMG_W-1:0] img_h;
  } cfg_t;

  // One kept row, as handed from front to back
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [CLS_W-1:0] cls;
    logic [VAL_W-1:0] conf;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] w;
    logic [VAL_W-1:0] h;
  } rec_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

  // trunc(p / 2^VAL_W) toward zero, saturated to +-BOX_LIMIT
  function automatic logic signed [EDGE_W-1:0] edge_px(input logic signed [EDGE_PROD_W-1:0] p);
    logic signed [EDGE_PROD_W-1:0] adj;
    logic signed [EDGE_PROD_W-VAL_W-1:0] q;
    begin
      adj = p;
      if (p < 0) begin
        adj = p + EDGE_PROD_W'((1 << VAL_W) - 1);
      end
      q = (EDGE_PROD_W-VAL_W)'(adj >>> VAL_W);
      if (q > BOX_LIMIT) begin
        edge_px = EDGE_W'(BOX_LIMIT);
      end else if (q < -BOX_LIMIT) begin
        edge_px = EDGE_W'(-BOX_LIMIT);
      end else begin
        edge_px = EDGE_W'(q);
      end
    end
  endfunction

  // trunc(p / 2^FRAC_W), saturated to BOX_LIMIT
  function automatic logic [SIZE_W-1:0] size_px(input logic [SIZE_PROD_W-1:0] p);
    logic [SIZE_PROD_W-FRAC_W-1:0] q;
    begin
      q = (SIZE_PROD_W-FRAC_W)'(p >> FRAC_W);
      if (q > BOX_LIMIT) begin
        size_px = SIZE_W'(BOX_LIMIT);
      end else begin
        size_px = SIZE_W'(q);
      end
    end
  endfunction

endpackage

// ===== rtl/drf_front.sv =====
`timescale 1ns / 1ps

module drf_front
  import drf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  input  logic [VAL_W-1:0] in_value_i,
  input  logic             in_eof_i,
  output logic             in_ready_o,
  input  q_stat_t          q_stat_i,
  output logic             push_o,
  output rec_t             rec_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [VAL_W-1:0] fields_q [FIELD_CNT];
  logic [VAL_W-1:0] best_score_q, best_score_d;
  logic [CLS_W-1:0] best_cls_q, best_cls_d;
  logic             accept;
  logic             last;
  logic             keep;
  logic             special_hit;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = (pos_q == POS_W'(ROW_LEN - 1));

  // Running argmax, first maximum wins
  always_comb begin
    best_score_d = best_score_q;
    best_cls_d   = best_cls_q;
    if (pos_q == POS_W'(FIELD_CNT)) begin
      best_score_d = in_value_i;
      best_cls_d   = '0;
    end else if (pos_q > POS_W'(FIELD_CNT) && in_value_i > best_score_q) begin
      best_score_d = in_value_i;
      best_cls_d   = CLS_W'(pos_q - POS_W'(FIELD_CNT));
    end
  end

  // Classify the row on its last element
  assign special_hit = (best_cls_d == cfg_i.special) && (fields_q[4] < cfg_i.special_th);
  assign keep = (fields_q[4] > cfg_i.conf_th) && !special_hit &&
                (best_score_d > cfg_i.score_th);

  assign push_o   = accept && last && keep;
  assign rec_o.row  = row_q;
  assign rec_o.cls  = best_cls_d;
  assign rec_o.conf = fields_q[4];
  assign rec_o.x    = fields_q[0];
  assign rec_o.y    = fields_q[1];
  assign rec_o.w    = fields_q[2];
  assign rec_o.h    = fields_q[3];

  // Advance position and row count; end of frame restarts both
  always_comb begin
    pos_d = pos_q;
    row_d = row_q;
    if (accept) begin
      if (last) begin
        pos_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
      end
      if (in_eof_i) begin
        pos_d = '0;
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      row_q        <= '0;
      best_score_q <= '0;
      best_cls_q   <= '0;
    end else begin
      pos_q <= pos_d;
      row_q <= row_d;
      if (accept) begin
        best_score_q <= best_score_d;
        best_cls_q   <= best_cls_d;
      end
    end
  end

  // Capture the box and confidence fields
  always_ff @(posedge clk_i) begin
    if (accept && pos_q < POS_W'(FIELD_CNT)) begin
      fields_q[pos_q[FLD_IDX_W-1:0]] <= in_value_i;
    end
  end

endmodule

// ===== rtl/drf_queue.sv =====
`timescale 1ns / 1ps

module drf_queue
  import drf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  rec_t    rec_i,
  input  logic    pop_i,
  output rec_t    rec_o,
  output q_stat_t stat_o
);

  rec_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic               do_push, do_pop;

  assign stat_o.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign rec_o        = mem[rd_q];

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= rec_i;
    end
  end

endmodule

// ===== rtl/drf_back.sv =====
`timescale 1ns / 1ps

module drf_back
  import drf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  rec_valid_i,
  input  rec_t                  rec_i,
  output logic                  pop_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic                          s1_valid_q;
  logic [ROW_W-1:0]              s1_row_q;
  logic [CLS_W-1:0]              s1_cls_q;
  logic [VAL_W-1:0]              s1_conf_q;
  logic signed [EDGE_PROD_W-1:0] s1_left_q, s1_top_q;
  logic [SIZE_PROD_W-1:0]        s1_w_q, s1_h_q;

  logic                          out_valid_q;
  logic [OUT_DATA_W-1:0]         out_data_q, out_data_d;

  logic                          out_free, s1_free;
  logic signed [DIFF_W-1:0]      dx, dy;
  logic signed [IMG_W:0]         sw, sh;
  logic signed [EDGE_PROD_W-1:0] left_d, top_d;
  logic [SIZE_PROD_W-1:0]        w_d, h_d;

  assign out_free = !out_valid_q || m_axis_tready;
  assign s1_free  = !s1_valid_q || out_free;
  assign pop_o    = rec_valid_i && s1_free;

  // Stage 1: scale centre offsets and sizes by the image size
  assign dx = $signed({1'b0, rec_i.x, 1'b0}) - $signed({2'b00, rec_i.w});
  assign dy = $signed({1'b0, rec_i.y, 1'b0}) - $signed({2'b00, rec_i.h});
  assign sw = $signed({1'b0, cfg_i.img_w});
  assign sh = $signed({1'b0, cfg_i.img_h});
  assign left_d = EDGE_PROD_W'(dx) * EDGE_PROD_W'(sw);
  assign top_d  = EDGE_PROD_W'(dy) * EDGE_PROD_W'(sh);
  assign w_d    = SIZE_PROD_W'(rec_i.w) * SIZE_PROD_W'(cfg_i.img_w);
  assign h_d    = SIZE_PROD_W'(rec_i.h) * SIZE_PROD_W'(cfg_i.img_h);

  // Stage 2: truncate, saturate and pack
  always_comb begin
    out_data_d = '0;
    out_data_d[OFS_ROW +: ROW_W]     = s1_row_q;
    out_data_d[OFS_CLS +: CLS_W]     = s1_cls_q;
    out_data_d[OFS_CONF +: VAL_W]    = s1_conf_q;
    out_data_d[OFS_LEFT +: EDGE_W]   = edge_px(s1_left_q);
    out_data_d[OFS_TOP +: EDGE_W]    = edge_px(s1_top_q);
    out_data_d[OFS_WIDTH +: SIZE_W]  = size_px(s1_w_q);
    out_data_d[OFS_HEIGHT +: SIZE_W] = size_px(s1_h_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= rec_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Hold payload while downstream stalls
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_row_q  <= rec_i.row;
      s1_cls_q  <= rec_i.cls;
      s1_conf_q <= rec_i.conf;
      s1_left_q <= left_d;
      s1_top_q  <= top_d;
      s1_w_q    <= w_d;
      s1_h_q    <= h_d;
    end
    if (out_free && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/detection_row_filter.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Payload
// s_axis    | in        | tdata[15:0] element_value; tlast end_of_frame
// m_axis    | out       | tdata: row_number, class_index, confidence, box_left,
//           |           |        box_top, box_width, box_height, zero pad to 96
// cfg       | in        | cfg_we_i, cfg_idx_i (register index), cfg_data_i
//
// One element is taken every cycle unless the queue is full; a kept row's result passes
// through the queue entry, the back multiply stage and the output register.
// A four-entry queue parts the front from the back: the input stalls only when
// the queue is full, so up to six results can be held while the output stalls.
// Reset clears position, row count, argmax, queue and pipeline valids and loads
// the register reset values.

module detection_row_filter
  import drf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Row elements
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VAL_W-1:0]      s_axis_tdata,   // [15:0] element_value
  input  logic                  s_axis_tlast,
  // Kept rows
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [14:0] row_number, [18:15] class_index, [34:19] confidence, [48:35] box_left,
  // [62:49] box_top, [75:63] box_width, [88:76] box_height, [95:89] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cfg_t    cfg_q;
  rec_t    push_rec, pop_rec;
  logic    push, pop;
  q_stat_t q_stat;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_th    <= VAL_W'(14746);
      cfg_q.score_th   <= VAL_W'(16384);
      cfg_q.special    <= CLS_W'(2);
      cfg_q.special_th <= VAL_W'(31130);
      cfg_q.img_w      <= IMG_W'(640);
      cfg_q.img_h      <= IMG_W'(640);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CONF_TH:    cfg_q.conf_th    <= cfg_data_i[VAL_W-1:0];
        CFG_SCORE_TH:   cfg_q.score_th   <= cfg_data_i[VAL_W-1:0];
        CFG_SPECIAL:    cfg_q.special    <= cfg_data_i[CLS_W-1:0];
        CFG_SPECIAL_TH: cfg_q.special_th <= cfg_data_i[VAL_W-1:0];
        CFG_IMG_W:      cfg_q.img_w      <= cfg_data_i[IMG_W-1:0];
        CFG_IMG_H:      cfg_q.img_h      <= cfg_data_i[IMG_W-1:0];
        default: ;
      endcase
    end
  end

  drf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_value_i (s_axis_tdata),
    .in_eof_i   (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  drf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .pop_i  (pop),
    .rec_o  (pop_rec),
    .stat_o (q_stat)
  );

  drf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .rec_valid_i   (!q_stat.empty),
    .rec_i         (pop_rec),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // A kept row is never offered to a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && q_stat.full))
    else $error("row pushed into full queue");

  // Fill count stays within the queue depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   q_stat.count <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count beyond depth");

  // Every delivered row passed the confidence filter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   m_axis_tvalid |-> (m_axis_tdata[OFS_CONF +: VAL_W] > cfg_q.conf_th))
    else $error("row below confidence threshold delivered");

  // Box sizes are saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   m_axis_tvalid |-> (m_axis_tdata[OFS_WIDTH +: SIZE_W] <= SIZE_W'(BOX_LIMIT) &&
                                      m_axis_tdata[OFS_HEIGHT +: SIZE_W] <= SIZE_W'(BOX_LIMIT)))
    else $error("box size not saturated");

endmodule
